// ===== rtl/lcs_pkg.sv =====
package lcs_pkg;

	localparam int MAX_CARDS = 64;
	localparam int IDX_W     = 6;
	localparam int SIZE_W    = 7;
	localparam int RNG_W     = 32;
	localparam int DVD_W     = RNG_W - 1;
	localparam int DCNT_W    = 5;

	localparam logic [RNG_W-1:0] LCG_MUL  = 32'd314159267;
	localparam logic [RNG_W-1:0] LCG_ADD  = 32'd13579;
	localparam logic [RNG_W-1:0] LCG_WRAP = 32'hFFFF_FFFF;
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_CARDS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_KSEL,
		S_MUL,
		S_ADD,
		S_DIVLD,
		S_DIV,
		S_RDI,
		S_RDP,
		S_CAPB,
		S_WRI,
		S_WRP,
		S_ORD,
		S_OSHOW
	} state_t;

	typedef struct packed {
		logic accept;
		logic init_wr;
		logic load_k;
		logic mul;
		logic add;
		logic div_load;
		logic div_step;
		logic rd_p;
		logic cap_a;
		logic cap_b;
		logic wr_i;
		logic wr_p;
		logic inc_i;
		logic clr_i;
	} cmd_t;

	typedef struct packed {
		logic size_zero;
		logic i_last;
		logic steps_done;
		logic div_last;
	} status_t;

	// x mod 3 by digit folding: 256 and 4 are both 1 mod 3
	function automatic logic [1:0] mod3(input logic [RNG_W-1:0] x);
		logic [9:0] b;
		logic [3:0] c;
		logic [2:0] d;
		logic [2:0] e;
		b = 10'(x[7:0]) + 10'(x[15:8]) + 10'(x[23:16]) + 10'(x[31:24]);
		c = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]) + 4'(b[9:8]);
		d = 3'(c[1:0]) + 3'(c[3:2]);
		e = (d >= 3'd3) ? d - 3'd3 : d;
		return (e == 3'd3) ? 2'd0 : e[1:0];
	endfunction

endpackage

// ===== rtl/lcg_card_shuffler_unit.sv =====
// Fisher-Yates card shuffler. A request (start while busy is low) carries a deck
// size and a reseed flag; sizes above 64 act as 64, a zero size only applies the
// reseed. The deck memory is loaded with identity, then one generator draw and
// swap is done per position, and the cards are then sent in position order on
// result_valid, with last on the final card. Results cannot be stalled. Each draw
// takes one to three generator steps (multiply, then add and wrap), then the
// one-bit-a-cycle remainder unit, then a swap (read i, read pos, capture, write i,
// write pos) on the single-read-port deck memory. The user must write the seed
// register with cfg_wr_en only while idle; the block itself does not enforce it.
module lcg_card_shuffler_unit
	import lcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [SIZE_W-1:0] deck_size,
	input  logic              reseed,
	input  logic              cfg_wr_en,
	input  logic [RNG_W-1:0]  cfg_wr_data,
	output logic              result_valid,
	output logic [IDX_W-1:0]  position,
	output logic [IDX_W-1:0]  card,
	output logic              last
);

	cmd_t    cmd;
	status_t status;

	lcs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy),
		.result_valid(result_valid)
	);

	lcs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.deck_size  (deck_size),
		.reseed     (reseed),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.position   (position),
		.card       (card),
		.last       (last)
	);

endmodule

// ===== rtl/lcs_ram.sv =====
module lcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/lcs_ctrl.sv =====
module lcs_ctrl
	import lcs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    result_valid
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		busy         = (state_q != S_IDLE);
		result_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					cmd.clr_i  = 1'b1;
					// a zero-size request only applies its reseed
					state_d    = status.size_zero ? S_IDLE : S_INIT;
				end
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (status.i_last) begin
					cmd.clr_i = 1'b1;
					state_d   = S_KSEL;
				end else begin
					cmd.inc_i = 1'b1;
				end
			end
			S_KSEL: begin
				cmd.load_k = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = status.steps_done ? S_DIVLD : S_MUL;
			end
			S_DIVLD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_RDI;
				end
			end
			S_RDI: begin
				state_d = S_RDP;
			end
			S_RDP: begin
				cmd.rd_p  = 1'b1;
				cmd.cap_a = 1'b1;
				state_d   = S_CAPB;
			end
			S_CAPB: begin
				cmd.cap_b = 1'b1;
				state_d   = S_WRI;
			end
			S_WRI: begin
				cmd.wr_i = 1'b1;
				state_d  = S_WRP;
			end
			S_WRP: begin
				cmd.wr_p = 1'b1;
				if (status.i_last) begin
					cmd.clr_i = 1'b1;
					state_d   = S_ORD;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = S_KSEL;
				end
			end
			S_ORD: begin
				state_d = S_OSHOW;
			end
			S_OSHOW: begin
				result_valid = 1'b1;
				if (status.i_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = S_ORD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lcs_dp.sv =====
module lcs_dp
	import lcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic [SIZE_W-1:0] deck_size,
	input  logic              reseed,
	input  logic              cfg_wr_en,
	input  logic [RNG_W-1:0]  cfg_wr_data,
	output logic [IDX_W-1:0]  position,
	output logic [IDX_W-1:0]  card,
	output logic              last
);

	logic [RNG_W-1:0]  seed_q;
	logic [RNG_W-1:0]  rng_q;
	logic [RNG_W-1:0]  prod_q;
	logic [SIZE_W-1:0] n_q;
	logic [IDX_W-1:0]  i_q;
	logic [1:0]        k_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dsr_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [IDX_W-1:0]  a_q;
	logic [IDX_W-1:0]  b_q;

	logic [RNG_W-1:0]  sum;
	logic [SIZE_W-1:0] trial;
	logic [IDX_W-1:0]  pos;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [IDX_W-1:0]  ram_rdata;

	assign sum   = prod_q + LCG_ADD;
	// remainder stays below 64, so its low six bits carry it
	assign trial = {rem_q[IDX_W-1:0], dvd_q[DVD_W-1]};
	assign pos   = i_q + rem_q[IDX_W-1:0];

	assign status.size_zero  = (deck_size == '0);
	assign status.i_last     = ({1'b0, i_q} + SIZE_W'(1) == n_q);
	assign status.steps_done = (k_q == 2'd0);
	assign status.div_last   = (dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd1;
			rng_q  <= 32'd1;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (cmd.accept && reseed) begin
				rng_q <= seed_q;
			end else if (cmd.add) begin
				rng_q <= (sum == LCG_WRAP) ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q <= (deck_size > SIZE_MAX) ? SIZE_MAX : deck_size;
		end
		if (cmd.clr_i) begin
			i_q <= '0;
		end else if (cmd.inc_i) begin
			i_q <= i_q + IDX_W'(1);
		end
		if (cmd.load_k) begin
			k_q <= mod3(rng_q);
		end else if (cmd.add) begin
			k_q <= k_q - 2'd1;
		end
		if (cmd.mul) begin
			prod_q <= RNG_W'(rng_q * LCG_MUL);
		end
		if (cmd.div_load) begin
			dvd_q  <= rng_q[RNG_W-1:1];
			rem_q  <= '0;
			dsr_q  <= n_q - {1'b0, i_q};
			dcnt_q <= DCNT_W'(DVD_W - 1);
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q  <= (trial >= dsr_q) ? trial - dsr_q : trial;
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
		if (cmd.cap_a) begin
			a_q <= ram_rdata;
		end
		if (cmd.cap_b) begin
			b_q <= ram_rdata;
		end
	end

	always_comb begin
		ram_we    = cmd.init_wr | cmd.wr_i | cmd.wr_p;
		ram_waddr = cmd.wr_p ? pos : i_q;
		priority if (cmd.init_wr) begin
			ram_wdata = i_q;
		end else if (cmd.wr_i) begin
			ram_wdata = b_q;
		end else begin
			ram_wdata = a_q;
		end
		ram_raddr = cmd.rd_p ? pos : i_q;
	end

	lcs_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_CARDS)
	) u_deck (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign position = i_q;
	assign card     = ram_rdata;
	assign last     = status.i_last;

endmodule

// ===== verif/lcg_card_shuffler_unit_tb.sv =====
module lcg_card_shuffler_unit_tb;
	import lcs_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE      = 60;

	typedef struct packed {
		logic [IDX_W-1:0] position;
		logic [IDX_W-1:0] card;
		logic             last;
	} dealt_card_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [SIZE_W-1:0] deck_size;
	logic              reseed;
	logic              cfg_wr_en;
	logic [RNG_W-1:0]  cfg_wr_data;
	logic              result_valid;
	logic [IDX_W-1:0]  position;
	logic [IDX_W-1:0]  card;
	logic              last;

	lcg_card_shuffler_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.deck_size   (deck_size),
		.reseed      (reseed),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.result_valid(result_valid),
		.position    (position),
		.card        (card),
		.last        (last)
	);

	// predictor state
	logic [RNG_W-1:0] rng_model;
	logic [RNG_W-1:0] seed_model;
	dealt_card_t      dealt_q[$];
	dealt_card_t      want;

	int fail_cnt;
	int req_cnt;
	int empty_req_cnt;
	int cards_checked;
	int seed_loads;
	int full_decks;
	int cycle_cnt;
	bit idle_off;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [RNG_W-1:0] lcg_next(input logic [RNG_W-1:0] s);
		logic [RNG_W-1:0] t;
		t = LCG_MUL * s + LCG_ADD;
		return (t == LCG_WRAP) ? '0 : t;
	endfunction

	function automatic void predict_shuffle(input logic [SIZE_W-1:0] size, input logic rs);
		logic [IDX_W-1:0] deck[MAX_CARDS];
		logic [IDX_W-1:0] tmp;
		logic [RNG_W-1:0] r;
		dealt_card_t      res;
		int n;
		int k;
		int pos;
		if (rs)
			rng_model = seed_model;
		n = (size > MAX_CARDS) ? MAX_CARDS : int'(size);
		req_cnt++;
		if (n == 0) begin
			empty_req_cnt++;
			return;
		end
		if (n == MAX_CARDS)
			full_decks++;
		for (int i = 0; i < n; i++)
			deck[i] = IDX_W'(i);
		for (int i = 0; i < n; i++) begin
			k = int'(rng_model % 3);
			for (int j = 0; j <= k; j++)
				rng_model = lcg_next(rng_model);
			r = rng_model >> 1;
			pos = i + int'(r % RNG_W'(n - i));
			tmp = deck[i];
			deck[i] = deck[pos];
			deck[pos] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			res.position = IDX_W'(i);
			res.card     = deck[i];
			res.last     = (i == n - 1);
			dealt_q.push_back(res);
		end
	endfunction

	function automatic int rand_gap();
		int p;
		if (idle_off)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		else if (p < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return SIZE_W'($urandom_range(1, 12));
		else if (p < 85)
			return SIZE_W'($urandom_range(13, 63));
		else if (p < 93)
			return SIZE_W'($urandom_range(64, 127));
		return '0;
	endfunction

	// one request; start stays high afterwards so back-to-back requests need no gap
	task automatic send_request(input logic [SIZE_W-1:0] size, input logic rs, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		deck_size <= size;
		reseed    <= rs;
		do @(posedge clk); while (busy);
		predict_shuffle(size, rs);
	endtask

	task automatic wait_dealt();
		start <= 1'b0;
		while (dealt_q.size() != 0)
			@(posedge clk);
		// a zero-size request yields nothing but may still be in flight
		repeat (SETTLE) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic load_seed(input logic [RNG_W-1:0] v);
		wait_dealt();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		seed_model = v;
		seed_loads++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (dealt_q.size() == 0) begin
				$error("unexpected card: position %0d card %0d last %0b", position, card, last);
				fail_cnt++;
			end else begin
				want = dealt_q.pop_front();
				cards_checked++;
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					fail_cnt++;
				end
				if (card !== want.card) begin
					$error("card: expected %0d, got %0d", want.card, card);
					fail_cnt++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d cards outstanding", cycle_cnt, dealt_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// generator starts at 1 out of reset, seed register also 1
	task automatic test_power_on_state();
		send_request(7'd5, 1'b0, 0);
		send_request(7'd1, 1'b0, rand_gap());
		send_request(7'd0, 1'b0, 0);
		send_request(7'd3, 1'b0, 0);
		wait_dealt();
	endtask

	// smallest, largest and saturating sizes
	task automatic test_deck_sizes();
		send_request(7'd2, 1'b1, 0);
		send_request(7'd63, 1'b0, 0);
		send_request(7'd64, 1'b1, 2);
		send_request(7'd65, 1'b0, 0);
		send_request(7'd127, 1'b1, 0);
		send_request(7'd0, 1'b1, 0);
		send_request(7'd9, 1'b0, 1);
		wait_dealt();
	endtask

	task automatic test_seed_register();
		logic [RNG_W-1:0] inv;
		send_request(7'd4, 1'b1, 0);
		load_seed('0);
		send_request(7'd4, 1'b1, 0);
		load_seed('1);
		send_request(7'd64, 1'b1, 0);
		// seed whose first step lands on 2^32-1 and wraps to zero
		inv = LCG_MUL;
		repeat (4)
			inv = inv * (32'd2 - LCG_MUL * inv);
		load_seed((LCG_WRAP - LCG_ADD) * inv);
		send_request(7'd6, 1'b1, 0);
		send_request(7'd6, 1'b1, 0);
		// reseed through an empty request, then shuffle without reseed
		load_seed(32'h1234_5678);
		send_request(7'd0, 1'b1, 0);
		send_request(7'd7, 1'b0, 0);
		wait_dealt();
	endtask

	task automatic test_random_shuffles();
		logic [RNG_W-1:0] seeds[6];
		seeds[0] = 32'd1;
		seeds[1] = $urandom;
		seeds[2] = '1;
		seeds[3] = '0;
		seeds[4] = $urandom;
		seeds[5] = 32'h8000_0000 | $urandom;
		for (int ph = 0; ph < 6; ph++) begin
			load_seed(seeds[ph]);
			idle_off = (ph == 2);
			for (int it = 0; it < 35; it++) begin
				if (ph == 3 && it == 17)
					wait_dealt();
				send_request(rand_size(), ($urandom_range(0, 99) < 20), rand_gap());
			end
		end
		idle_off = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		start       <= 1'b0;
		deck_size   <= '0;
		reseed      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		rng_model   = 32'd1;
		seed_model  = 32'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_state();
		test_deck_sizes();
		test_seed_register();
		test_random_shuffles();
		wait_dealt();

		$display("Ran %0d shuffle requests (%0d empty, %0d full decks) under %0d seed loads,",
			req_cnt, empty_req_cnt, full_decks, seed_loads);
		$display("checked %0d dealt cards field by field.", cards_checked);
		if (fail_cnt == 0 && dealt_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
